/* hw/rtl/i2c_acp_pkg.sv */
// ----------------------------------------------------------------------------
// i2c_acp_pkg: shared types and constants of the ADC channel poller
// Bus event codes, phase encoding and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package i2c_acp_pkg;

  localparam int unsigned Channels  = 4;
  localparam int unsigned ChanW     = 2;
  localparam int unsigned ReadingW  = 12;

  localparam logic [7:0]  EvMask      = 8'hF8;
  localparam logic [7:0]  PtrConv     = 8'h00;
  localparam logic [7:0]  PtrConf     = 8'h01;
  localparam logic [6:0]  DevAddrRst  = 7'd72;
  localparam logic [15:0] ConfBaseRst = 16'd18048;

  typedef enum logic [7:0] {
    EV_START    = 8'h08,
    EV_RESTART  = 8'h10,
    EV_SLAW_ACK = 8'h18,
    EV_TX_ACK   = 8'h28,
    EV_TX_NACK  = 8'h30,
    EV_SLAR_ACK = 8'h40,
    EV_RX_ACK   = 8'h50
  } ev_e;

  typedef enum logic [1:0] {
    PH_CONF  = 2'd0,
    PH_POINT = 2'd1,
    PH_READ  = 2'd2
  } phase_e;

  typedef enum logic {
    REG_DEV_ADDR  = 1'b0,
    REG_CONF_BASE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic                       acted;
    logic                       data_valid;
    logic [7:0]                 data_byte;
    logic                       start_req;
    logic                       stop_req;
    logic                       ack_enable;
    logic                       reading_valid;
    logic [ChanW-1:0]           reading_channel;
    logic signed [ReadingW-1:0] reading_value;
  } rslt_t;

endpackage

`default_nettype wire

/* hw/rtl/i2c_acp_seq.sv */
// ----------------------------------------------------------------------------
// i2c_acp_seq: phase sequencer of the ADC channel poller
// Decodes one bus event against the phase state, produces the bus action and
// advances phase, byte count, channel and the held MSB on each beat.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_acp_seq import i2c_acp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        fire_i,
  input  wire logic [7:0]  status_code_i,
  input  wire logic [7:0]  rx_byte_i,
  output rslt_t            rslt_o
);

  logic [6:0]       dev_addr_q;
  logic [15:0]      conf_base_q;
  phase_e           phase_q, phase_d;
  logic [1:0]       byte_count_q, byte_count_d;
  logic [ChanW-1:0] chan_q, chan_d;
  logic [7:0]       msb_q, msb_d;

  logic [7:0]         ev;
  logic [7:0]         addr_w;
  logic [15:0]        conf_word;
  logic [7:0]         conf_byte;
  logic [1:0]         bc_inc;
  logic [ChanW:0]     chan_inc;
  logic [15:0]        word;
  logic signed [16:0] word_adj;

  assign ev        = status_code_i & EvMask;
  assign addr_w    = {dev_addr_q, 1'b0};
  assign conf_word = conf_base_q | {2'b00, chan_q, 12'h000};
  assign conf_byte = (byte_count_q != 2'd0) ? conf_word[7:0] : conf_word[15:8];
  assign bc_inc    = byte_count_q + 2'd1;
  assign chan_inc  = {1'b0, chan_q} + {{ChanW{1'b0}}, 1'b1};
  assign word      = {msb_q, rx_byte_i};
  // bias negatives by 15 so the arithmetic shift truncates toward zero
  assign word_adj  = $signed({word[15], word}) + $signed({13'd0, {4{word[15]}}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q  <= DevAddrRst;
      conf_base_q <= ConfBaseRst;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_DEV_ADDR:  dev_addr_q  <= cfg_data_i[6:0];
        REG_CONF_BASE: conf_base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    phase_d      = phase_q;
    byte_count_d = byte_count_q;
    chan_d       = chan_q;
    msb_d        = msb_q;
    case (phase_q)
      PH_CONF: begin
        if (ev == EV_SLAW_ACK) begin
          byte_count_d = 2'd0;
        end else if (ev == EV_TX_ACK) begin
          if (bc_inc == 2'd3) begin
            phase_d      = PH_POINT;
            byte_count_d = 2'd0;
          end else begin
            byte_count_d = bc_inc;
          end
        end else if (ev == EV_TX_NACK) begin
          phase_d      = PH_CONF;
          byte_count_d = 2'd0;
          chan_d       = '0;
        end
      end
      PH_POINT: begin
        if (ev == EV_TX_ACK) phase_d = PH_READ;
      end
      PH_READ: begin
        if (ev == EV_SLAR_ACK) begin
          byte_count_d = 2'd0;
        end else if (ev == EV_RX_ACK) begin
          if (byte_count_q == 2'd0) begin
            msb_d        = rx_byte_i;
            byte_count_d = 2'd1;
          end else begin
            phase_d      = PH_CONF;
            byte_count_d = 2'd0;
            chan_d       = (chan_inc >= (ChanW+1)'(Channels)) ? '0 : chan_inc[ChanW-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  // bus action
  always_comb begin
    rslt_o = '0;
    case (phase_q)
      PH_CONF: begin
        if (ev == EV_START || ev == EV_RESTART) begin
          rslt_o.acted      = 1'b1;
          rslt_o.data_valid = 1'b1;
          rslt_o.data_byte  = addr_w;
        end else if (ev == EV_SLAW_ACK) begin
          rslt_o.acted      = 1'b1;
          rslt_o.data_valid = 1'b1;
          rslt_o.data_byte  = PtrConf;
        end else if (ev == EV_TX_ACK) begin
          rslt_o.acted      = 1'b1;
          rslt_o.data_valid = 1'b1;
          rslt_o.data_byte  = conf_byte;
          rslt_o.start_req  = (bc_inc == 2'd3);
          rslt_o.stop_req   = (bc_inc == 2'd3);
        end else if (ev == EV_TX_NACK) begin
          rslt_o.acted     = 1'b1;
          rslt_o.start_req = 1'b1;
          rslt_o.stop_req  = 1'b1;
        end
      end
      PH_POINT: begin
        if (ev == EV_START || ev == EV_RESTART) begin
          rslt_o.acted      = 1'b1;
          rslt_o.data_valid = 1'b1;
          rslt_o.data_byte  = addr_w;
        end else if (ev == EV_SLAW_ACK) begin
          rslt_o.acted      = 1'b1;
          rslt_o.data_valid = 1'b1;
          rslt_o.data_byte  = PtrConv;
        end else if (ev == EV_TX_ACK) begin
          rslt_o.acted     = 1'b1;
          rslt_o.start_req = 1'b1;
          rslt_o.stop_req  = 1'b1;
        end
      end
      PH_READ: begin
        if (ev == EV_START || ev == EV_RESTART) begin
          rslt_o.acted      = 1'b1;
          rslt_o.data_valid = 1'b1;
          rslt_o.data_byte  = addr_w | 8'h01;
        end else if (ev == EV_SLAR_ACK) begin
          rslt_o.acted      = 1'b1;
          rslt_o.ack_enable = 1'b1;
        end else if (ev == EV_RX_ACK) begin
          rslt_o.acted = 1'b1;
          if (byte_count_q == 2'd0) begin
            rslt_o.ack_enable = 1'b1;
          end else begin
            rslt_o.start_req       = 1'b1;
            rslt_o.stop_req        = 1'b1;
            rslt_o.reading_valid   = 1'b1;
            rslt_o.reading_channel = chan_q;
            rslt_o.reading_value   = word_adj[15:4];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_CONF;
      byte_count_q <= 2'd0;
      chan_q       <= '0;
    end else if (fire_i) begin
      phase_q      <= phase_d;
      byte_count_q <= byte_count_d;
      chan_q       <= chan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) msb_q <= msb_d;
  end

  a_reading_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && rslt_o.reading_valid |=> phase_q == PH_CONF && byte_count_q == 2'd0)
    else $error("reading did not return sequencer to config phase");

  a_msb_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && phase_q == PH_READ && ev == EV_RX_ACK && byte_count_q == 2'd0
    |=> phase_q == PH_READ && byte_count_q == 2'd1)
    else $error("MSB beat did not move to LSB wait");

  a_idle_event_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !rslt_o.acted |=> $stable(phase_q) && $stable(chan_q) && $stable(byte_count_q))
    else $error("unhandled event changed sequencer state");

endmodule

`default_nettype wire

/* hw/rtl/i2c_acp_rslt_reg.sv */
// ----------------------------------------------------------------------------
// i2c_acp_rslt_reg: result register of the ADC channel poller
// Holds one finished result until the downstream side takes the beat.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_acp_rslt_reg import i2c_acp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  load_i,
  input  wire rslt_t rslt_i,
  input  wire logic  ready_i,
  output logic       valid_o,
  output logic       free_o,
  output rslt_t      rslt_o
);

  logic  valid_q;
  rslt_t rslt_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign rslt_o  = rslt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) rslt_q <= rslt_i;
  end

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !ready_i |=> valid_q && $stable(rslt_q))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

/* hw/rtl/i2c_adc_channel_poller_core.sv */
// ----------------------------------------------------------------------------
// i2c_adc_channel_poller_core: round-robin ADC poller over an I2C master
// Turns bus status events into bus actions and signed conversion readings.
//
//   channel   dir  payload
//   s_axis    in   tuser = status_code, tdata = rx_byte
//   m_axis    out  tdata = bus action and reading fields
//   cfg       in   cfg_index_i selects register, cfg_data_i holds value
//
// One event per cycle is sustained while m_axis does not stall; an event is
// held in the input register and decoded into the result register, from
// which it is offered on m_axis. Sequencer state advances as the event
// moves into the result register. Reset puts the sequencer in the config
// phase on channel 0 with default address and config word. A stall on
// m_axis holds the result and backs up into s_axis_tready once the input
// register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_adc_channel_poller_core import i2c_acp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic [7:0]  s_axis_tuser,   // [7:0] status_code
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] acted, [1] data_valid, [9:2] data_byte, [10] start_req, [11] stop_req,
  // [12] ack_enable, [13] reading_valid, [15:14] reading_channel,
  // [27:16] reading_value, [31:28] zero
  output logic [31:0]      m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  logic       in_valid_q;
  logic [7:0] status_q;
  logic [7:0] rx_q;
  logic       out_free;
  logic       fire;
  rslt_t      rslt;
  rslt_t      rslt_out;

  assign cfg_ready_o   = 1'b1;
  assign fire          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      status_q <= s_axis_tuser;
      rx_q     <= s_axis_tdata;
    end
  end

  i2c_acp_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fire_i        (fire),
    .status_code_i (status_q),
    .rx_byte_i     (rx_q),
    .rslt_o        (rslt)
  );

  i2c_acp_rslt_reg u_rslt_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (in_valid_q),
    .rslt_i  (rslt),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .free_o  (out_free),
    .rslt_o  (rslt_out)
  );

  assign m_axis_tdata = {4'd0,
                         rslt_out.reading_value,
                         rslt_out.reading_channel,
                         rslt_out.reading_valid,
                         rslt_out.ack_enable,
                         rslt_out.stop_req,
                         rslt_out.start_req,
                         rslt_out.data_byte,
                         rslt_out.data_valid,
                         rslt_out.acted};

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_free |=> in_valid_q && $stable(status_q) && $stable(rx_q))
    else $error("buffered event lost under output stall");

endmodule

`default_nettype wire
